// ===== hdl/tdts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tdts_pkg;

	localparam int NUM_SLOTS    = 8;
	localparam int COUNTER_BITS = 16;
	localparam int PRIO_BITS    = 16;
	localparam int SLOT_W       = $clog2(NUM_SLOTS);
	localparam int SUM_W        = ((COUNTER_BITS > PRIO_BITS) ? COUNTER_BITS : PRIO_BITS) + 1;
	localparam int LFSR_W       = 32;
	localparam int ADDR_W       = 3;

	localparam logic [LFSR_W-1:0] LFSR_FEEDBACK = 32'hD000_0001;
	localparam logic [SUM_W-1:0]  CNT_MAX_EXT   = SUM_W'((64'd1 << COUNTER_BITS) - 64'd1);

	localparam logic [ADDR_W-1:0] REG_MODE_ADDR = 3'd0;
	localparam logic [ADDR_W-1:0] REG_SEED_ADDR = 3'd4;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	localparam logic MODE_SHORTEST = 1'b0;
	localparam logic MODE_PRIORITY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEC,
		ST_SCAN,
		ST_REFILL,
		ST_FINAL
	} tdts_state_t;

	typedef struct packed {
		logic capture;
		logic dec;
		logic scan_start;
		logic scan_step;
		logic refill_step;
		logic commit_pick;
		logic use_run;
		logic out_load;
	} tdts_cmd_t;

	typedef struct packed {
		logic kind_load;
		logic run_idle;
		logic dec_zero;
		logic scan_last;
		logic all_zero;
		logic refilled;
		logic out_free;
	} tdts_sts_t;

endpackage

`default_nettype wire

// ===== hdl/tdts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdts_ctrl
	import tdts_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire tdts_sts_t sts,
	output tdts_cmd_t      cmd
);

	tdts_state_t state_q;
	tdts_state_t state_d;
	logic        accept;

	assign accept = in_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (sts.kind_load) begin
						state_d = ST_FINAL;
					end else if (sts.run_idle) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_DEC;
					end
				end
			end
			ST_DEC: begin
				state_d = sts.dec_zero ? ST_SCAN : ST_FINAL;
			end
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_d = (sts.all_zero && !sts.refilled) ? ST_REFILL : ST_FINAL;
				end
			end
			ST_REFILL: begin
				if (sts.scan_last) begin
					state_d = ST_SCAN;
				end
			end
			ST_FINAL: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = accept;
				cmd.scan_start = accept && !sts.kind_load && sts.run_idle;
			end
			ST_DEC: begin
				cmd.use_run    = 1'b1;
				cmd.dec        = 1'b1;
				cmd.scan_start = sts.dec_zero;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					if (sts.all_zero && !sts.refilled) begin
						cmd.scan_start = 1'b1;
					end else begin
						cmd.commit_pick = 1'b1;
					end
				end
			end
			ST_REFILL: begin
				cmd.refill_step = 1'b1;
				cmd.scan_start  = sts.scan_last;
			end
			ST_FINAL: begin
				cmd.use_run  = 1'b1;
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/tdts_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdts_datapath
	import tdts_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                mode,
	input  wire logic                seed_load,
	input  wire logic [LFSR_W-1:0]   seed,
	input  wire logic                kind,
	input  wire logic [2:0]          slot_index,
	input  wire logic [15:0]         load_counter,
	input  wire logic [15:0]         load_priority,
	input  wire tdts_cmd_t           cmd,
	output tdts_sts_t                sts,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [2:0]               running_slot,
	output logic                     switched,
	output logic [15:0]              running_counter,
	output logic                     refilled,
	output logic                     stuck
);

	logic [COUNTER_BITS-1:0] cnt_q [NUM_SLOTS];
	logic [PRIO_BITS-1:0]    prio_q [NUM_SLOTS];

	logic [SLOT_W-1:0]       run_q;
	logic [SLOT_W-1:0]       prev_q;
	logic [SLOT_W-1:0]       scan_q;
	logic [SLOT_W-1:0]       pick_q;
	logic [COUNTER_BITS-1:0] best_q;
	logic                    any_nz_q;
	logic                    refilled_q;
	logic                    stuck_q;
	logic [LFSR_W-1:0]       lfsr_q;
	logic                    out_valid_q;

	logic [SLOT_W-1:0]       rd_addr;
	logic [COUNTER_BITS-1:0] rd_cnt;
	logic [PRIO_BITS-1:0]    rd_prio;
	logic [COUNTER_BITS-1:0] dec_val;
	logic [LFSR_W-1:0]       lfsr_next;
	logic [SUM_W-1:0]        refill_sum;
	logic [COUNTER_BITS-1:0] refill_val;
	logic                    take;
	logic [SLOT_W-1:0]       pick_d;
	logic                    scan_nz;
	logic                    load_ok;
	logic [SLOT_W-1:0]       load_slot;

	assign rd_addr = cmd.use_run ? run_q : scan_q;
	assign rd_cnt  = cnt_q[rd_addr];
	assign rd_prio = prio_q[rd_addr];
	assign dec_val = (rd_cnt != '0) ? (rd_cnt - COUNTER_BITS'(1)) : '0;

	assign lfsr_next  = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_FEEDBACK : '0);
	assign refill_sum = SUM_W'(rd_cnt >> 1) + SUM_W'(rd_prio);

	always_comb begin
		if (mode == MODE_PRIORITY) begin
			refill_val = (refill_sum > CNT_MAX_EXT) ? '1 : COUNTER_BITS'(refill_sum);
		end else begin
			refill_val = lfsr_next[COUNTER_BITS-1:0];
		end
	end

	// largest with highest index, or smallest nonzero with lowest index
	always_comb begin
		if (mode == MODE_PRIORITY) begin
			take = (scan_q == SLOT_W'(1)) || (rd_cnt >= best_q);
		end else begin
			take = (rd_cnt != '0) && ((pick_q == '0) || (rd_cnt < best_q));
		end
	end

	assign pick_d    = take ? scan_q : pick_q;
	assign scan_nz   = any_nz_q || (rd_cnt != '0);
	assign load_slot = SLOT_W'(slot_index);
	assign load_ok   = (slot_index != 3'd0) && (32'(slot_index) < NUM_SLOTS);

	assign sts.kind_load = (kind == KIND_LOAD);
	assign sts.run_idle  = (run_q == '0);
	assign sts.dec_zero  = (dec_val == '0);
	assign sts.scan_last = (scan_q == SLOT_W'(NUM_SLOTS - 1));
	assign sts.all_zero  = !scan_nz;
	assign sts.refilled  = refilled_q;
	assign sts.out_free  = !out_valid_q || !out_stall;

	// slot register file, one write a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				cnt_q[SLOT_W'(i)]  <= '0;
				prio_q[SLOT_W'(i)] <= '0;
			end
		end else if (cmd.capture && (kind == KIND_LOAD)) begin
			if (load_ok) begin
				cnt_q[load_slot]  <= COUNTER_BITS'(load_counter);
				prio_q[load_slot] <= load_priority;
			end
		end else if (cmd.dec) begin
			cnt_q[run_q] <= dec_val;
		end else if (cmd.refill_step) begin
			cnt_q[scan_q] <= refill_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= '0;
			prev_q     <= '0;
			scan_q     <= SLOT_W'(1);
			pick_q     <= '0;
			best_q     <= '0;
			any_nz_q   <= 1'b0;
			refilled_q <= 1'b0;
			stuck_q    <= 1'b0;
			lfsr_q     <= LFSR_W'(1);
		end else begin
			if (seed_load) begin
				lfsr_q <= (seed == '0) ? LFSR_W'(1) : seed;
			end else if (cmd.refill_step && (mode == MODE_SHORTEST)) begin
				lfsr_q <= lfsr_next;
			end
			if (cmd.capture) begin
				prev_q     <= run_q;
				refilled_q <= 1'b0;
				stuck_q    <= 1'b0;
			end
			if (cmd.refill_step) begin
				refilled_q <= 1'b1;
			end
			if (cmd.scan_start) begin
				scan_q   <= SLOT_W'(1);
				pick_q   <= '0;
				best_q   <= '0;
				any_nz_q <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_q   <= scan_q + SLOT_W'(1);
				any_nz_q <= scan_nz;
				if (take) begin
					pick_q <= scan_q;
					best_q <= rd_cnt;
				end
			end else if (cmd.refill_step) begin
				scan_q <= scan_q + SLOT_W'(1);
			end
			if (cmd.commit_pick) begin
				run_q   <= scan_nz ? pick_d : '0;
				stuck_q <= !scan_nz && (mode == MODE_PRIORITY);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			running_slot    <= 3'(run_q);
			switched        <= (run_q != prev_q);
			running_counter <= 16'(rd_cnt);
			refilled        <= refilled_q;
			stuck           <= stuck_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/tick_driven_task_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tick-driven task scheduler: eight task slots, each with a remaining-time
// counter and a refill priority; slot 0 is the idle task. A load item sets one
// slot, a tick decrements the running slot and reschedules when it hits zero
// or when the idle task runs. Every input transfer yields exactly one result
// transfer. Items are handled one at a time: a load goes straight to the
// result; a tick decrements the running slot and, when it reschedules, runs
// a pick scan, then, if every task counter is zero, a refill pass and a second scan.
// The pick scan and the refill pass both use the single read port of the
// slot register file, which they walk one slot per cycle. A new
// item is taken while the previous result still waits in the output
// register. Configuration sits on an APB-style port: policy_mode at 0x0,
// random_seed at 0x4; writing the seed reloads the refill generator at once
// (a zero seed loads 1). Write registers only while the block is idle.

module tick_driven_task_scheduler
	import tdts_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// apb configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// item channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              kind,
	input  wire logic [2:0]        slot_index,
	input  wire logic [15:0]       load_counter,
	input  wire logic [15:0]       load_priority,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [2:0]             running_slot,
	output logic                   switched,
	output logic [15:0]            running_counter,
	output logic                   refilled,
	output logic                   stuck
);

	logic        mode_q;
	logic [31:0] seed_q;
	logic        wr_en;
	logic        seed_load;
	tdts_cmd_t   cmd;
	tdts_sts_t   sts;

	// register write completes on the access phase; no wait states
	assign pready    = 1'b1;
	assign wr_en     = psel && penable && pwrite;
	assign seed_load = wr_en && (paddr == REG_SEED_ADDR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SHORTEST;
			seed_q <= 32'd1;
		end else if (wr_en) begin
			case (paddr)
				REG_MODE_ADDR: mode_q <= pwdata[0];
				REG_SEED_ADDR: seed_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	// read-back of the registers, zero elsewhere
	always_comb begin
		case (paddr)
			REG_MODE_ADDR: prdata = {31'd0, mode_q};
			REG_SEED_ADDR: prdata = seed_q;
			default:       prdata = '0;
		endcase
	end

	// sequencer: accept, decrement, pick scan, refill pass, result
	tdts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// slot register file, generator, pick tracking and result register
	tdts_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.mode            (mode_q),
		.seed_load       (seed_load),
		.seed            (pwdata),
		.kind            (kind),
		.slot_index      (slot_index),
		.load_counter    (load_counter),
		.load_priority   (load_priority),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.running_slot    (running_slot),
		.switched        (switched),
		.running_counter (running_counter),
		.refilled        (refilled),
		.stuck           (stuck)
	);

endmodule

`default_nettype wire

// ===== hdl/tdts_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdts_checker
	import tdts_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [2:0]        running_slot,
	input wire logic [15:0]       running_counter,
	input wire logic              refilled,
	input wire logic              stuck
);

	// one item at a time: the channel closes right after a transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("item channel open right after a transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(running_slot)
			&& $stable(running_counter)))
		else $error("stalled result changed");

	a_stuck_refilled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stuck) |-> (refilled && running_slot == 3'd0))
		else $error("stuck without refill or with a task chosen");

	// the idle slot is never loaded, so its counter stays zero
	a_idle_counter: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && running_slot == 3'd0) |-> (running_counter == 16'd0))
		else $error("idle slot shows a nonzero counter");

endmodule

bind tick_driven_task_scheduler tdts_checker u_tdts_checker (.*);

`default_nettype wire
